// ===== rtl/ncle_pkg.sv =====
// Shared types, command codes and lookup tables for the noise channel.
// Used by every module of the noise channel; depends on nothing.
package ncle_pkg;

  typedef enum logic [2:0] {
    CMD_REG_WRITE = 3'd0,
    CMD_TIMER     = 3'd1,
    CMD_ENV       = 3'd2,
    CMD_LEN       = 3'd3,
    CMD_ENABLE    = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    OFF_ENV    = 2'd0,
    OFF_UNUSED = 2'd1,
    OFF_CTRL   = 2'd2,
    OFF_LEN    = 2'd3
  } reg_off_e;

  localparam logic [14:0] LFSR_RESET   = 15'd1;
  localparam logic [11:0] PERIOD_RESET = 12'h004;
  localparam logic [3:0]  DECAY_MAX    = 4'd15;

  typedef struct packed {
    logic [2:0] command;
    logic [1:0] reg_offset;
    logic [7:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [3:0] amplitude;
    logic       length_active;
  } out_item_t;

  typedef struct packed {
    logic       wr_env;
    logic       wr_ctrl;
    logic       wr_len;
    logic       timer_tick;
    logic       env_tick;
    logic       len_tick;
    logic       en_wr;
    logic [7:0] data;
  } ctrl_t;

  function automatic logic [11:0] period_lookup(input logic [4:0] idx);
    logic [11:0] p;
    case (idx)
      5'd0:  p = 12'h004;
      5'd1:  p = 12'h008;
      5'd2:  p = 12'h010;
      5'd3:  p = 12'h020;
      5'd4:  p = 12'h040;
      5'd5:  p = 12'h060;
      5'd6:  p = 12'h080;
      5'd7:  p = 12'h0A0;
      5'd8:  p = 12'h0CA;
      5'd9:  p = 12'h0FE;
      5'd10: p = 12'h17C;
      5'd11: p = 12'h1FC;
      5'd12: p = 12'h2FA;
      5'd13: p = 12'h3F8;
      5'd14: p = 12'h7F2;
      5'd15: p = 12'hFEC;
      5'd16: p = 12'h004;
      5'd17: p = 12'h008;
      5'd18: p = 12'h00E;
      5'd19: p = 12'h01E;
      5'd20: p = 12'h03C;
      5'd21: p = 12'h058;
      5'd22: p = 12'h076;
      5'd23: p = 12'h094;
      5'd24: p = 12'h0BC;
      5'd25: p = 12'h0EC;
      5'd26: p = 12'h162;
      5'd27: p = 12'h1D8;
      5'd28: p = 12'h2C4;
      5'd29: p = 12'h3B0;
      5'd30: p = 12'h762;
      5'd31: p = 12'hEC2;
      default: p = PERIOD_RESET;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] length_lookup(input logic [4:0] idx);
    logic [7:0] l;
    case (idx)
      5'd0:  l = 8'd10;
      5'd1:  l = 8'd254;
      5'd2:  l = 8'd20;
      5'd3:  l = 8'd2;
      5'd4:  l = 8'd40;
      5'd5:  l = 8'd4;
      5'd6:  l = 8'd80;
      5'd7:  l = 8'd6;
      5'd8:  l = 8'd160;
      5'd9:  l = 8'd8;
      5'd10: l = 8'd60;
      5'd11: l = 8'd10;
      5'd12: l = 8'd14;
      5'd13: l = 8'd12;
      5'd14: l = 8'd26;
      5'd15: l = 8'd14;
      5'd16: l = 8'd12;
      5'd17: l = 8'd16;
      5'd18: l = 8'd24;
      5'd19: l = 8'd18;
      5'd20: l = 8'd48;
      5'd21: l = 8'd20;
      5'd22: l = 8'd96;
      5'd23: l = 8'd22;
      5'd24: l = 8'd192;
      5'd25: l = 8'd24;
      5'd26: l = 8'd72;
      5'd27: l = 8'd26;
      5'd28: l = 8'd16;
      5'd29: l = 8'd28;
      5'd30: l = 8'd32;
      5'd31: l = 8'd30;
      default: l = 8'd0;
    endcase
    return l;
  endfunction

endpackage

// ===== rtl/noise_channel_lfsr_envelope.sv =====
// Noise channel top level: input register, command decode, output register.
// Depends on ncle_pkg, ncle_timer, ncle_env and ncle_len.
// Results pass the input and output registers and are held until their own transfer.
// Throughput is one item per cycle unless stalled; state is updated in a single pass.
// Synchronous reset restores all channel state, the region and both stages.
// The configuration port is always ready and takes effect at the next control write.
module noise_channel_lfsr_envelope (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  ncle_pkg::in_item_t  item,
  output logic                result_valid,
  input  logic                result_stall,
  output ncle_pkg::out_item_t result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);
  import ncle_pkg::*;

  logic      s1_valid;
  in_item_t  s1_item;
  logic      advance;
  logic      go;
  ctrl_t     ctrl;
  logic      pal_region;
  logic [14:0] lfsr_next;
  logic      halt_loop;
  logic      vol_fixed_next;
  logic [3:0] volume_setting_next;
  logic [3:0] env_decay_next;
  logic      channel_enabled_next;
  logic [7:0] length_count_next;
  out_item_t result_next;

  assign advance    = !result_valid || !result_stall;
  assign go         = s1_valid && advance;
  assign item_stall = s1_valid && !advance;
  assign cfg_ready  = 1'b1;

  always_comb begin
    ctrl            = '0;
    ctrl.data       = s1_item.write_data;
    case (s1_item.command)
      CMD_REG_WRITE: begin
        ctrl.wr_env  = go && (s1_item.reg_offset == OFF_ENV);
        ctrl.wr_ctrl = go && (s1_item.reg_offset == OFF_CTRL);
        ctrl.wr_len  = go && (s1_item.reg_offset == OFF_LEN);
      end
      CMD_TIMER:  ctrl.timer_tick = go;
      CMD_ENV:    ctrl.env_tick   = go;
      CMD_LEN:    ctrl.len_tick   = go;
      CMD_ENABLE: ctrl.en_wr      = go;
      default:    ctrl.data       = s1_item.write_data;
    endcase
  end

  ncle_timer u_timer (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .pal_region (pal_region),
    .lfsr_next  (lfsr_next)
  );

  ncle_env u_env (
    .clk                 (clk),
    .rst                 (rst),
    .ctrl                (ctrl),
    .halt_loop           (halt_loop),
    .vol_fixed_next      (vol_fixed_next),
    .volume_setting_next (volume_setting_next),
    .env_decay_next      (env_decay_next)
  );

  ncle_len u_len (
    .clk                  (clk),
    .rst                  (rst),
    .ctrl                 (ctrl),
    .halt_loop            (halt_loop),
    .channel_enabled_next (channel_enabled_next),
    .length_count_next    (length_count_next)
  );

  always_comb begin
    result_next.length_active = (length_count_next != 8'd0);
    if (lfsr_next[0] || !channel_enabled_next || length_count_next == 8'd0) begin
      result_next.amplitude = 4'd0;
    end else if (vol_fixed_next) begin
      result_next.amplitude = volume_setting_next;
    end else begin
      result_next.amplitude = env_decay_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
      pal_region   <= 1'b0;
    end else begin
      if (!item_stall) begin
        s1_valid <= item_valid;
      end
      if (advance) begin
        result_valid <= s1_valid;
      end
      if (cfg_valid && cfg_ready) begin
        pal_region <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      s1_item <= item;
    end
    if (go) begin
      result <= result_next;
    end
  end

  // A nonzero level is only ever reported with an active length counter.
  a_amp_needs_length: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.amplitude != 4'd0 |-> result.length_active)
    else $error("amplitude nonzero with empty length counter");

  // The input side only stalls while a held item waits for the output register.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> s1_valid && result_valid && result_stall)
    else $error("input stalled without a blocked result");

  // A held item that cannot move keeps the output register occupied.
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("pending result was lost");

endmodule

// ===== rtl/ncle_timer.sv =====
// Timer divider, period register and 15-bit noise LFSR.
// Depends on ncle_pkg for the control struct and the period table.
module ncle_timer (
  input  logic          clk,
  input  logic          rst,
  input  ncle_pkg::ctrl_t ctrl,
  input  logic          pal_region,
  output logic [14:0]   lfsr_next
);
  import ncle_pkg::*;

  logic [14:0] lfsr;
  logic [11:0] timer_count;
  logic [11:0] timer_count_next;
  logic [11:0] timer_period;
  logic [11:0] timer_period_next;
  logic        short_mode;
  logic        short_mode_next;
  logic        feedback;

  always_comb begin
    timer_count_next  = timer_count;
    timer_period_next = timer_period;
    short_mode_next   = short_mode;
    lfsr_next         = lfsr;
    feedback          = lfsr[0] ^ (short_mode ? lfsr[6] : lfsr[1]);
    if (ctrl.wr_ctrl) begin
      short_mode_next   = ctrl.data[7];
      timer_period_next = period_lookup({pal_region, ctrl.data[3:0]});
    end
    if (ctrl.timer_tick) begin
      if (timer_count == 12'd0) begin
        timer_count_next = timer_period - 12'd1;
        lfsr_next        = {feedback, lfsr[14:1]};
      end else begin
        timer_count_next = timer_count - 12'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr         <= LFSR_RESET;
      timer_count  <= 12'd0;
      timer_period <= PERIOD_RESET;
      short_mode   <= 1'b0;
    end else begin
      lfsr         <= lfsr_next;
      timer_count  <= timer_count_next;
      timer_period <= timer_period_next;
      short_mode   <= short_mode_next;
    end
  end

  // The shift register can never reach the all-zero state.
  a_lfsr_nonzero: assert property (@(posedge clk) disable iff (rst) lfsr != 15'd0)
    else $error("noise LFSR reached zero");

  // An expiring tick reloads the counter from the period register.
  a_timer_reload: assert property (@(posedge clk) disable iff (rst)
    ctrl.timer_tick && timer_count == 12'd0 && !ctrl.wr_ctrl
      |=> timer_count == timer_period - 12'd1)
    else $error("timer did not reload on expiry");

endmodule

// ===== rtl/ncle_env.sv =====
// Envelope generator: volume and halt/loop register, divider and decay counter.
// Depends on ncle_pkg for the control struct and decay constant.
module ncle_env (
  input  logic            clk,
  input  logic            rst,
  input  ncle_pkg::ctrl_t ctrl,
  output logic            halt_loop,
  output logic            vol_fixed_next,
  output logic [3:0]      volume_setting_next,
  output logic [3:0]      env_decay_next
);
  import ncle_pkg::*;

  logic       vol_fixed;
  logic [3:0] volume_setting;
  logic       halt_loop_next;
  logic       start_pending;
  logic       start_pending_next;
  logic [3:0] env_divider;
  logic [3:0] env_divider_next;
  logic [3:0] env_decay;

  always_comb begin
    halt_loop_next      = halt_loop;
    vol_fixed_next      = vol_fixed;
    volume_setting_next = volume_setting;
    start_pending_next  = start_pending;
    env_divider_next    = env_divider;
    env_decay_next      = env_decay;
    if (ctrl.wr_env) begin
      halt_loop_next      = ctrl.data[5];
      vol_fixed_next      = ctrl.data[4];
      volume_setting_next = ctrl.data[3:0];
    end
    if (ctrl.wr_len) begin
      start_pending_next = 1'b1;
    end
    if (ctrl.env_tick) begin
      if (start_pending) begin
        start_pending_next = 1'b0;
        env_decay_next     = DECAY_MAX;
        env_divider_next   = volume_setting;
      end else if (env_divider != 4'd0) begin
        env_divider_next = env_divider - 4'd1;
      end else begin
        env_divider_next = volume_setting;
        if (env_decay != 4'd0) begin
          env_decay_next = env_decay - 4'd1;
        end else if (halt_loop) begin
          env_decay_next = DECAY_MAX;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      halt_loop      <= 1'b0;
      vol_fixed      <= 1'b0;
      volume_setting <= 4'd0;
      start_pending  <= 1'b0;
      env_divider    <= 4'd0;
      env_decay      <= 4'd0;
    end else begin
      halt_loop      <= halt_loop_next;
      vol_fixed      <= vol_fixed_next;
      volume_setting <= volume_setting_next;
      start_pending  <= start_pending_next;
      env_divider    <= env_divider_next;
      env_decay      <= env_decay_next;
    end
  end

  // A tick with the start flag set restarts the decay at full level.
  a_env_start: assert property (@(posedge clk) disable iff (rst)
    ctrl.env_tick && start_pending |=> env_decay == DECAY_MAX)
    else $error("envelope start did not reload decay");

endmodule

// ===== rtl/ncle_len.sv =====
// Length counter and channel enable.
// Depends on ncle_pkg for the control struct and the length table.
module ncle_len (
  input  logic            clk,
  input  logic            rst,
  input  ncle_pkg::ctrl_t ctrl,
  input  logic            halt_loop,
  output logic            channel_enabled_next,
  output logic [7:0]      length_count_next
);
  import ncle_pkg::*;

  logic       channel_enabled;
  logic [7:0] length_count;

  always_comb begin
    channel_enabled_next = channel_enabled;
    length_count_next    = length_count;
    if (ctrl.wr_len && channel_enabled) begin
      length_count_next = length_lookup(ctrl.data[7:3]);
    end
    if (ctrl.len_tick && !halt_loop && length_count != 8'd0) begin
      length_count_next = length_count - 8'd1;
    end
    if (ctrl.en_wr) begin
      channel_enabled_next = ctrl.data[0];
      if (!ctrl.data[0]) begin
        length_count_next = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_enabled <= 1'b0;
      length_count    <= 8'd0;
    end else begin
      channel_enabled <= channel_enabled_next;
      length_count    <= length_count_next;
    end
  end

  // A disabled channel always holds an empty length counter.
  a_len_disabled: assert property (@(posedge clk) disable iff (rst)
    !channel_enabled |-> length_count == 8'd0)
    else $error("length counter nonzero while disabled");

endmodule
